### design/mlls_pkg.sv
package mlls_pkg;

   // Build-time defaults
   localparam int unsigned NUM_MOTORS_DEF = 4;

   // Register reset values
   localparam logic [15:0] LINK_TIMEOUT_RESET = 16'd100;
   localparam logic [15:0] RETRY_GAP_RESET    = 16'd500;
   localparam logic [7:0]  RETRY_LIMIT_RESET  = 8'd5;

   // Register indexes (byte address is 4 * index)
   localparam logic [1:0] REG_ONLINE_TIMEOUT = 2'd0;
   localparam logic [1:0] REG_RETRY_INTERVAL = 2'd1;
   localparam logic [1:0] REG_MAX_RETRIES    = 2'd2;

   // Request kinds
   localparam logic [1:0] KIND_CHECK  = 2'd0;
   localparam logic [1:0] KIND_ENABLE = 2'd1;
   localparam logic [1:0] KIND_ESTOP  = 2'd2;

   // Link lifecycle states
   typedef enum logic [1:0] {
      ST_OFFLINE  = 2'd0,
      ST_ENABLING = 2'd1,
      ST_ONLINE   = 2'd2,
      ST_FAULT    = 2'd3
   } life_type;

   // Per-motor record held in the record memory
   typedef struct packed {
      logic [31:0] enable_stamp;
      logic [31:0] seen_stamp;
      logic [7:0]  retry_count;
      logic [7:0]  fault_latch;
   } rec_type;

endpackage

### design/mlls_rec_mem.sv
module mlls_rec_mem #(
   parameter int unsigned DEPTH = 4,
   parameter int unsigned IDX_W = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_idx,
   output mlls_pkg::rec_type rd_rec,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  mlls_pkg::rec_type wr_rec
);
   import mlls_pkg::*;

   rec_type              rec_mem [DEPTH];
   logic [DEPTH-1:0]     valid_ff;
   rec_type              rd_data_ff;
   logic                 hit_ff;
   logic                 byp_ff;
   rec_type              byp_rec_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rec_mem[wr_idx] <= wr_rec;
      end
      if (rd_en) begin
         rd_data_ff <= rec_mem[rd_idx];
         byp_rec_ff <= wr_rec;
      end
   end

   // Track written entries; catch a read that coincides with a write to the same entry
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
         byp_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         if (rd_en) begin
            hit_ff <= valid_ff[rd_idx];
            byp_ff <= wr_en && (wr_idx == rd_idx);
         end
      end
   end

   // Forward the fresh write, else stored data, else the reset value
   always_comb begin
      if (byp_ff) begin
         rd_rec = byp_rec_ff;
      end else if (hit_ff) begin
         rd_rec = rd_data_ff;
      end else begin
         rd_rec = '0;
      end
   end

endmodule

### design/motor_link_lifecycle_supervisor.sv
// Supervises the link lifecycle (offline, enabling, online, fault) of up to NUM_MOTORS motors.
// One request is taken every cycle unless a stalled response holds the update stage. The
// motor's record (stamps, retry count, fault code) is read from a record memory with one read
// and one write port at the accepting edge; the update stage then updates it, writes it back
// and loads the response into an output register. Back-to-back requests to the same motor
// see the previous update through a forwarding path. Lifecycle states sit in flip-flops so
// that the every-online flag reflects every motor at once. Entries never written read as
// zero through per-entry valid bits, so no clearing pass follows reset. Registers sit at byte
// addresses 0 (online timeout), 4 (retry interval) and 8 (max retries).
module motor_link_lifecycle_supervisor #(
   parameter int unsigned NUM_MOTORS = mlls_pkg::NUM_MOTORS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [1:0]  req_motor,
   input  logic [31:0] req_now_ms,
   input  logic        req_link_online,
   input  logic        req_already_enabled,
   input  logic [7:0]  req_fault_in,
   input  logic        req_frame_accepted,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_motor_out,
   output logic [1:0]  rsp_life_state,
   output logic        rsp_send_enable,
   output logic        rsp_send_stop,
   output logic [7:0]  rsp_fault_held,
   output logic [7:0]  rsp_retries_used,
   output logic        rsp_motor_ok,
   output logic        rsp_every_online,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mlls_pkg::*;

   localparam int unsigned IDX_W      = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
   localparam logic [4:0]  NUM_MOTORS5 = 5'(NUM_MOTORS);

   // configuration
   logic [15:0] timeout_ff, timeout_in;
   logic [15:0] interval_ff, interval_in;
   logic [7:0]  max_retries_ff, max_retries_in;
   logic        csr_wr;

   // update stage
   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_kind_ff;
   logic [1:0]  s1_motor_ff;
   logic [31:0] s1_now_ff;
   logic        s1_online_ff;
   logic        s1_enabled_ff;
   logic [7:0]  s1_fault_ff;
   logic        s1_accepted_ff;
   logic        s1_advance;
   logic        s1_in_range;
   logic [IDX_W-1:0] s1_idx;
   logic        req_accept;

   // lifecycle states
   life_type    life_ff [NUM_MOTORS];
   life_type    life_in [NUM_MOTORS];
   life_type    st_cur, st_nxt;

   // record memory
   rec_type     rec_cur, rec_nxt;
   logic        rec_wr;

   // update results
   logic        send_en, send_stop, ok, all_on;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_motor_ff;
   logic [1:0]  rsp_state_ff;
   logic        rsp_send_en_ff;
   logic        rsp_send_stop_ff;
   logic [7:0]  rsp_fault_ff;
   logic [7:0]  rsp_retries_ff;
   logic        rsp_ok_ff;
   logic        rsp_all_ff;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   // decode register writes
   always_comb begin
      timeout_in     = timeout_ff;
      interval_in    = interval_ff;
      max_retries_in = max_retries_ff;
      if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_ONLINE_TIMEOUT: timeout_in     = csr_pwdata[15:0];
            REG_RETRY_INTERVAL: interval_in    = csr_pwdata[15:0];
            REG_MAX_RETRIES:    max_retries_in = csr_pwdata[7:0];
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff     <= LINK_TIMEOUT_RESET;
         interval_ff    <= RETRY_GAP_RESET;
         max_retries_ff <= RETRY_LIMIT_RESET;
      end else begin
         timeout_ff     <= timeout_in;
         interval_ff    <= interval_in;
         max_retries_ff <= max_retries_in;
      end
   end

   // read back registers
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_ONLINE_TIMEOUT: csr_prdata = {16'd0, timeout_ff};
         REG_RETRY_INTERVAL: csr_prdata = {16'd0, interval_ff};
         REG_MAX_RETRIES:    csr_prdata = {24'd0, max_retries_ff};
         default:            csr_prdata = '0;
      endcase
   end

   // ---------------- request intake ----------------
   assign s1_advance  = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !s1_valid_ff || s1_advance;
   assign req_accept  = req_valid && req_ready;
   assign s1_valid_in = req_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // hold the request fields for the update cycle
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_kind_ff     <= req_kind;
         s1_motor_ff    <= req_motor;
         s1_now_ff      <= req_now_ms;
         s1_online_ff   <= req_link_online;
         s1_enabled_ff  <= req_already_enabled;
         s1_fault_ff    <= req_fault_in;
         s1_accepted_ff <= req_frame_accepted;
      end
   end

   assign s1_in_range = {3'd0, s1_motor_ff} < NUM_MOTORS5;
   assign s1_idx      = IDX_W'(s1_motor_ff);
   assign rec_wr      = s1_advance && s1_in_range;

   mlls_rec_mem #(
      .DEPTH (NUM_MOTORS),
      .IDX_W (IDX_W)
   ) u_rec_mem (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (req_accept),
      .rd_idx (IDX_W'(req_motor)),
      .rd_rec (rec_cur),
      .wr_en  (rec_wr),
      .wr_idx (s1_idx),
      .wr_rec (rec_nxt)
   );

   // ---------------- lifecycle update ----------------
   assign st_cur = s1_in_range ? life_ff[s1_idx] : ST_OFFLINE;

   always_comb begin
      st_nxt    = st_cur;
      rec_nxt   = rec_cur;
      send_en   = 1'b0;
      send_stop = 1'b0;
      ok        = 1'b0;
      unique case (s1_kind_ff)
         KIND_CHECK: begin
            unique case (st_cur)
               ST_ENABLING: begin
                  if (s1_online_ff) begin
                     st_nxt              = ST_ONLINE;
                     rec_nxt.seen_stamp  = s1_now_ff;
                     rec_nxt.fault_latch = '0;
                     ok                  = 1'b1;
                  end else if ((s1_now_ff - rec_cur.enable_stamp) > {16'd0, timeout_ff}) begin
                     st_nxt = ST_OFFLINE;
                     ok     = 1'b1;
                  end
               end
               ST_ONLINE: begin
                  ok = 1'b1;
                  if (s1_online_ff) begin
                     rec_nxt.seen_stamp = s1_now_ff;
                     if (s1_fault_ff != '0) begin
                        rec_nxt.fault_latch = s1_fault_ff;
                        st_nxt              = ST_FAULT;
                        ok                  = 1'b0;
                     end
                  end else if ((s1_now_ff - rec_cur.seen_stamp) > {16'd0, timeout_ff}) begin
                     st_nxt = ST_OFFLINE;
                     ok     = 1'b0;
                  end
               end
               ST_OFFLINE: begin
                  if ((rec_cur.retry_count < max_retries_ff) &&
                      ((s1_now_ff - rec_cur.enable_stamp) > {16'd0, interval_ff}) &&
                      s1_accepted_ff) begin
                     st_nxt               = ST_ENABLING;
                     rec_nxt.enable_stamp = s1_now_ff;
                     rec_nxt.retry_count  = 8'(rec_cur.retry_count + 8'd1);
                     send_en              = 1'b1;
                  end
               end
               default: begin
                  if (s1_fault_ff == '0) begin
                     rec_nxt.fault_latch = '0;
                     st_nxt              = ST_ONLINE;
                  end
               end
            endcase
         end
         KIND_ENABLE: begin
            if (!s1_enabled_ff && s1_accepted_ff) begin
               st_nxt               = ST_ENABLING;
               rec_nxt.enable_stamp = s1_now_ff;
               rec_nxt.retry_count  = 8'd1;
               send_en              = 1'b1;
            end
         end
         KIND_ESTOP: begin
            st_nxt    = ST_OFFLINE;
            send_stop = 1'b1;
         end
         default: ;
      endcase
   end

   // commit the new state of the addressed motor
   always_comb begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
         life_in[i] = life_ff[i];
      end
      if (rec_wr) begin
         life_in[s1_idx] = st_nxt;
      end
   end

   // check every motor after the update
   always_comb begin
      all_on = 1'b1;
      for (int i = 0; i < NUM_MOTORS; i++) begin
         if (life_in[i] != ST_ONLINE) begin
            all_on = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_MOTORS; i++) begin
            life_ff[i] <= ST_OFFLINE;
         end
      end else begin
         life_ff <= life_in;
      end
   end

   // ---------------- response register ----------------
   assign rsp_valid_in = s1_advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // load the response; drop everything but the motor number and the every-online flag for a motor out of range
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_motor_ff     <= s1_motor_ff;
         rsp_state_ff     <= s1_in_range ? st_nxt : ST_OFFLINE;
         rsp_send_en_ff   <= s1_in_range && send_en;
         rsp_send_stop_ff <= s1_in_range && send_stop;
         rsp_fault_ff     <= s1_in_range ? rec_nxt.fault_latch : '0;
         rsp_retries_ff   <= s1_in_range ? rec_nxt.retry_count : '0;
         rsp_ok_ff        <= s1_in_range && ok;
         rsp_all_ff       <= all_on;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_motor_out    = rsp_motor_ff;
   assign rsp_life_state   = rsp_state_ff;
   assign rsp_send_enable  = rsp_send_en_ff;
   assign rsp_send_stop    = rsp_send_stop_ff;
   assign rsp_fault_held   = rsp_fault_ff;
   assign rsp_retries_used = rsp_retries_ff;
   assign rsp_motor_ok     = rsp_ok_ff;
   assign rsp_every_online = rsp_all_ff;

`ifndef ASSERT_OFF
   // a stalled update keeps its request
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> s1_valid_ff)
      else $error("update stage lost a request while stalled");

   // enable and stop are never requested together
   a_frames_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_send_en_ff && rsp_send_stop_ff))
      else $error("enable and stop frames in one response");

   // a sent enable leaves the motor enabling with at least one attempt counted
   a_enable_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_send_en_ff) |->
         (rsp_state_ff == ST_ENABLING) && (rsp_retries_ff != '0))
      else $error("enable sent without entering enabling");
`endif

endmodule

### tb/sv/tb_motor_link_lifecycle_supervisor.sv
`timescale 1ns / 1ps

module tb_motor_link_lifecycle_supervisor;
   import mlls_pkg::*;

   localparam int unsigned LINKS       = 4;
   localparam int unsigned STALL_LIMIT = 1000;
   localparam int unsigned PER_SETTING = 150;
   // kind code the block leaves unused
   localparam logic [1:0]  KIND_SPARE  = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  motor;
      logic [31:0] now_ms;
      logic        link_online;
      logic        already_enabled;
      logic [7:0]  fault_in;
      logic        frame_accepted;
   } request_type;

   typedef struct {
      request_type req;
      int unsigned gap;
      bit          drain_first;
   } pending_type;

   typedef struct packed {
      logic [1:0] motor_out;
      life_type   life_state;
      logic       send_enable;
      logic       send_stop;
      logic [7:0] fault_held;
      logic [7:0] retries_used;
      logic       motor_ok;
      logic       every_online;
   } link_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_kind = '0;
   logic [1:0]  req_motor = '0;
   logic [31:0] req_now_ms = '0;
   logic        req_link_online = 1'b0;
   logic        req_already_enabled = 1'b0;
   logic [7:0]  req_fault_in = '0;
   logic        req_frame_accepted = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_motor_out;
   logic [1:0]  rsp_life_state;
   logic        rsp_send_enable;
   logic        rsp_send_stop;
   logic [7:0]  rsp_fault_held;
   logic [7:0]  rsp_retries_used;
   logic        rsp_motor_ok;
   logic        rsp_every_online;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predicted supervisor state and register copy
   life_type    link_st [LINKS];
   logic [31:0] enable_at [LINKS];
   logic [31:0] seen_at [LINKS];
   logic [7:0]  attempts [LINKS];
   logic [7:0]  latched_fault [LINKS];
   logic [15:0] cfg_timeout = LINK_TIMEOUT_RESET;
   logic [15:0] cfg_interval = RETRY_GAP_RESET;
   logic [7:0]  cfg_max_tries = RETRY_LIMIT_RESET;

   pending_type     queued_requests[$];
   link_report_type predicted_reports[$];
   link_report_type seen_report;
   link_report_type next_report;

   bit          req_fired = 1'b0;
   bit          rsp_fired = 1'b0;
   int unsigned req_hold = 0;
   int unsigned rsp_wait = 0;
   int unsigned rsp_gap_max = 10;
   int unsigned stall_cycles = 0;
   logic [31:0] now_cursor = '0;

   int unsigned mismatches = 0;
   int unsigned n_requests = 0;
   int unsigned n_responses = 0;
   int unsigned n_settings = 0;
   int unsigned n_enables = 0;
   int unsigned n_stops = 0;
   int unsigned n_fault_state = 0;
   int unsigned n_every_online = 0;

   motor_link_lifecycle_supervisor i_dut (.*);

   always #5 clock = ~clock;

   // Advance the predicted state of one link by one request
   function automatic link_report_type supervise_link(input request_type r);
      link_report_type o;
      logic [31:0]     since_enable;
      logic [31:0]     since_seen;
      int              m;
      m = r.motor;
      since_enable = r.now_ms - enable_at[m];
      since_seen = r.now_ms - seen_at[m];
      o = '0;
      o.motor_out = r.motor;
      case (r.kind)
         KIND_CHECK: begin
            case (link_st[m])
               ST_ENABLING: begin
                  if (r.link_online) begin
                     link_st[m] = ST_ONLINE;
                     seen_at[m] = r.now_ms;
                     latched_fault[m] = '0;
                     o.motor_ok = 1'b1;
                  end else if (since_enable > {16'd0, cfg_timeout}) begin
                     // an enable that timed out still counts as handled
                     link_st[m] = ST_OFFLINE;
                     o.motor_ok = 1'b1;
                  end
               end
               ST_ONLINE: begin
                  o.motor_ok = 1'b1;
                  if (r.link_online) begin
                     seen_at[m] = r.now_ms;
                     if (r.fault_in != 8'd0) begin
                        latched_fault[m] = r.fault_in;
                        link_st[m] = ST_FAULT;
                        o.motor_ok = 1'b0;
                     end
                  end else if (since_seen > {16'd0, cfg_timeout}) begin
                     link_st[m] = ST_OFFLINE;
                     o.motor_ok = 1'b0;
                  end
               end
               ST_OFFLINE: begin
                  if (attempts[m] < cfg_max_tries && since_enable > {16'd0, cfg_interval} &&
                      r.frame_accepted) begin
                     link_st[m] = ST_ENABLING;
                     enable_at[m] = r.now_ms;
                     attempts[m] = attempts[m] + 8'd1;
                     o.send_enable = 1'b1;
                  end
               end
               default: begin
                  // leave fault once the feedback is clean; seen time stays
                  if (r.fault_in == 8'd0) begin
                     latched_fault[m] = '0;
                     link_st[m] = ST_ONLINE;
                  end
               end
            endcase
         end
         KIND_ENABLE: begin
            if (!r.already_enabled && r.frame_accepted) begin
               link_st[m] = ST_ENABLING;
               enable_at[m] = r.now_ms;
               attempts[m] = 8'd1;
               o.send_enable = 1'b1;
            end
         end
         KIND_ESTOP: begin
            link_st[m] = ST_OFFLINE;
            o.send_stop = 1'b1;
         end
         default: ;
      endcase
      o.life_state = link_st[m];
      o.fault_held = latched_fault[m];
      o.retries_used = attempts[m];
      o.every_online = 1'b1;
      foreach (link_st[i])
         if (link_st[i] != ST_ONLINE)
            o.every_online = 1'b0;
      return o;
   endfunction

   function automatic pending_type directed_item(input logic [1:0] kind,
                                                 input logic [1:0] motor,
                                                 input logic [31:0] now, input logic link,
                                                 input logic enabled, input logic [7:0] fault,
                                                 input logic accepted);
      pending_type p;
      p.req = {kind, motor, now, link, enabled, fault, accepted};
      p.gap = $urandom_range(0, 10);
      p.drain_first = 1'b0;
      return p;
   endfunction

   // Draw a request, mostly well-formed checks with the time creeping forward
   function automatic pending_type random_item(input bit quiet);
      pending_type p;
      int unsigned pick;
      int unsigned step;
      pick = $urandom_range(0, 99);
      if (pick < 50)
         step = $urandom_range(0, cfg_timeout / 2);
      else if (pick < 75)
         step = $urandom_range(0, 2 * cfg_timeout + 2);
      else if (pick < 90)
         step = $urandom_range(0, 2 * cfg_interval + 2);
      else if (pick < 98)
         step = $urandom_range(0, 1000000);
      else
         step = $urandom;
      now_cursor = now_cursor + step;
      pick = $urandom_range(0, 99);
      if (pick < 72)
         p.req.kind = KIND_CHECK;
      else if (pick < 84)
         p.req.kind = KIND_ENABLE;
      else if (pick < 93)
         p.req.kind = KIND_ESTOP;
      else
         p.req.kind = KIND_SPARE;
      p.req.motor = 2'($urandom_range(0, LINKS - 1));
      p.req.now_ms = now_cursor;
      p.req.link_online = ($urandom_range(0, 99) < 75);
      p.req.already_enabled = ($urandom_range(0, 99) < 20);
      p.req.fault_in = ($urandom_range(0, 99) < 12) ? 8'($urandom_range(1, 255)) : 8'd0;
      p.req.frame_accepted = ($urandom_range(0, 99) < 85);
      p.gap = quiet ? 0 : $urandom_range(0, 10);
      p.drain_first = ($urandom_range(0, 59) == 0);
      return p;
   endfunction

   task automatic check_report(input link_report_type want, input link_report_type got);
      if (got.motor_out !== want.motor_out || got.life_state !== want.life_state ||
          got.send_enable !== want.send_enable || got.send_stop !== want.send_stop ||
          got.fault_held !== want.fault_held || got.retries_used !== want.retries_used ||
          got.motor_ok !== want.motor_ok || got.every_online !== want.every_online) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch at %0t: expected motor %0d state %0d en %0d stop %0d fault %0d",
                     $realtime, want.motor_out, want.life_state, want.send_enable,
                     want.send_stop, want.fault_held);
            $display("   tries %0d ok %0d all %0d; got motor %0d state %0d en %0d stop %0d",
                     want.retries_used, want.motor_ok, want.every_online, got.motor_out,
                     got.life_state, got.send_enable, got.send_stop);
            $display("   fault %0d tries %0d ok %0d all %0d",
                     got.fault_held, got.retries_used, got.motor_ok, got.every_online);
         end
      end
   endtask

   // Write one register through the APB port and read it back
   task automatic program_reg(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_ONLINE_TIMEOUT: cfg_timeout = value[15:0];
         REG_RETRY_INTERVAL: cfg_interval = value[15:0];
         REG_MAX_RETRIES:    cfg_max_tries = value[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== value) begin
         mismatches++;
         if (mismatches <= 10)
            $display("register %0d read back %0h, expected %0h", idx, csr_prdata, value);
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic wait_for_drain();
      while (queued_requests.size() != 0 || req_valid || predicted_reports.size() != 0)
         @(posedge clock);
   endtask

   // Request driver: hold each request until taken, then idle as drawn
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_hold = 0;
      end else if (!req_valid || req_fired) begin
         if (queued_requests.size() == 0 || req_hold < queued_requests[0].gap ||
             (queued_requests[0].drain_first && predicted_reports.size() != 0)) begin
            req_valid <= 1'b0;
            if (queued_requests.size() != 0 && req_hold < queued_requests[0].gap)
               req_hold++;
         end else begin
            {req_kind, req_motor, req_now_ms, req_link_online, req_already_enabled,
             req_fault_in, req_frame_accepted} <= queued_requests[0].req;
            req_valid <= 1'b1;
            queued_requests.pop_front();
            req_hold = 0;
         end
      end
   end

   // Response side: stall for a drawn number of cycles after each response
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_fired)
            rsp_wait = (rsp_gap_max == 0) ? 0 : $urandom_range(0, rsp_gap_max);
         if (rsp_wait > 0) begin
            rsp_ready <= 1'b0;
            rsp_wait--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Monitor: check responses against the oldest prediction, predict new requests
   always @(posedge clock) begin
      req_fired = !reset && req_valid && req_ready;
      rsp_fired = !reset && rsp_valid && rsp_ready;
      if (rsp_fired) begin
         seen_report = {rsp_motor_out, rsp_life_state, rsp_send_enable, rsp_send_stop,
                        rsp_fault_held, rsp_retries_used, rsp_motor_ok, rsp_every_online};
         n_responses++;
         if (predicted_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response for motor %0d at %0t with nothing outstanding",
                        rsp_motor_out, $realtime);
         end else begin
            check_report(predicted_reports.pop_front(), seen_report);
         end
      end
      if (req_fired) begin
         next_report = supervise_link({req_kind, req_motor, req_now_ms, req_link_online,
                                       req_already_enabled, req_fault_in,
                                       req_frame_accepted});
         predicted_reports.push_back(next_report);
         n_requests++;
         n_enables += next_report.send_enable;
         n_stops += next_report.send_stop;
         n_fault_state += (next_report.life_state == ST_FAULT);
         n_every_online += next_report.every_online;
      end
      // drop out if nothing moves for too long
      if (req_fired || rsp_fired)
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("no handshake for %0d cycles, %0d responses outstanding",
                  stall_cycles, predicted_reports.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      logic [15:0] timeout_val;
      logic [15:0] interval_val;
      logic [7:0]  tries_val;
      bit          quiet;
      pending_type p;
      foreach (link_st[i]) begin
         link_st[i] = ST_OFFLINE;
         enable_at[i] = '0;
         seen_at[i] = '0;
         attempts[i] = '0;
         latched_fault[i] = '0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed requests under the reset register values
      queued_requests.push_back(directed_item(KIND_CHECK, 2'd0, 32'd0, 1'b0, 1'b0, 8'd0, 1'b1));
      queued_requests.push_back(directed_item(KIND_CHECK, 2'd0, 32'd501, 1'b0, 1'b0, 8'd0, 1'b1));
      queued_requests.push_back(directed_item(KIND_CHECK, 2'd0, 32'd550, 1'b0, 1'b0, 8'd0, 1'b1));
      queued_requests.push_back(directed_item(KIND_CHECK, 2'd0, 32'd650, 1'b0, 1'b0, 8'd0, 1'b1));
      queued_requests.push_back(directed_item(KIND_ENABLE, 2'd0, 32'd660, 1'b0, 1'b1, 8'd0, 1'b1));
      queued_requests.push_back(directed_item(KIND_ENABLE, 2'd0, 32'd670, 1'b0, 1'b0, 8'd0, 1'b0));
      queued_requests.push_back(directed_item(KIND_ENABLE, 2'd0, 32'd700, 1'b0, 1'b0, 8'd0, 1'b1));
      p = directed_item(KIND_CHECK, 2'd0, 32'd710, 1'b1, 1'b0, 8'd0, 1'b0);
      p.drain_first = 1'b1;
      queued_requests.push_back(p);
      queued_requests.push_back(directed_item(KIND_CHECK, 2'd0, 32'd720, 1'b1, 1'b0, 8'd0, 1'b0));
      queued_requests.push_back(directed_item(KIND_CHECK, 2'd0, 32'd730, 1'b1, 1'b0, 8'hFF, 1'b0));
      queued_requests.push_back(directed_item(KIND_CHECK, 2'd0, 32'd740, 1'b1, 1'b0, 8'd7, 1'b0));
      queued_requests.push_back(directed_item(KIND_CHECK, 2'd0, 32'd750, 1'b0, 1'b0, 8'd0, 1'b0));
      queued_requests.push_back(directed_item(KIND_CHECK, 2'd0, 32'd830, 1'b0, 1'b0, 8'd0, 1'b0));
      queued_requests.push_back(directed_item(KIND_CHECK, 2'd0, 32'd831, 1'b0, 1'b0, 8'd0, 1'b0));
      queued_requests.push_back(directed_item(KIND_ESTOP, 2'd0, 32'd840, 1'b0, 1'b0, 8'd0, 1'b0));
      queued_requests.push_back(directed_item(KIND_SPARE, 2'd0, 32'd850, 1'b1, 1'b1, 8'd9, 1'b1));
      // bring every link up across the time wrap, then stop one
      for (int k = 0; k < LINKS; k++)
         queued_requests.push_back(directed_item(KIND_ENABLE, 2'(k), 32'hFFFF_FFF0, 1'b0,
                                                 1'b0, 8'd0, 1'b1));
      for (int k = 0; k < LINKS; k++)
         queued_requests.push_back(directed_item(KIND_CHECK, 2'(k), 32'd5, 1'b1, 1'b0, 8'd0,
                                                 1'b0));
      queued_requests.push_back(directed_item(KIND_ESTOP, 2'd3, 32'hFFFF_FFFF, 1'b1, 1'b1,
                                              8'hFF, 1'b1));
      wait_for_drain();
      n_settings = 1;
      now_cursor = 32'd1000;

      // Random requests under a series of register settings
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               timeout_val = 16'd1;
               interval_val = 16'd1;
               tries_val = 8'd255;
               rsp_gap_max = 10;
            end
            1: begin
               timeout_val = 16'hFFFF;
               interval_val = 16'hFFFF;
               tries_val = 8'd0;
               rsp_gap_max = 0;
               now_cursor = 32'hFFFF_0000;
            end
            2: begin
               timeout_val = 16'($urandom_range(20, 300));
               interval_val = 16'($urandom_range(50, 800));
               tries_val = 8'($urandom_range(1, 8));
               rsp_gap_max = 10;
            end
            3: begin
               timeout_val = 16'($urandom_range(1, 60));
               interval_val = 16'($urandom_range(1, 100));
               tries_val = 8'($urandom_range(2, 6));
               rsp_gap_max = 3;
            end
            default: begin
               timeout_val = LINK_TIMEOUT_RESET;
               interval_val = RETRY_GAP_RESET;
               tries_val = RETRY_LIMIT_RESET;
               rsp_gap_max = 10;
            end
         endcase
         program_reg(REG_ONLINE_TIMEOUT, {16'd0, timeout_val});
         program_reg(REG_RETRY_INTERVAL, {16'd0, interval_val});
         program_reg(REG_MAX_RETRIES, {24'd0, tries_val});
         n_settings++;
         quiet = 1'b0;
         for (int k = 0; k < PER_SETTING; k++) begin
            if (k % 40 == 0)
               quiet = ($urandom_range(0, 2) == 0);
            queued_requests.push_back(random_item(quiet));
         end
         wait_for_drain();
      end

      repeat (8) @(posedge clock);
      $display("%0d requests over %0d register settings: %0d enable frames, %0d stop frames",
               n_requests, n_settings, n_enables, n_stops);
      $display("%0d responses in fault state, %0d with every link online, %0d mismatches",
               n_fault_state, n_every_online, mismatches);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### files.f
design/mlls_pkg.sv
design/mlls_rec_mem.sv
design/motor_link_lifecycle_supervisor.sv
tb/sv/tb_motor_link_lifecycle_supervisor.sv
